### sv/assert_macros.svh
// shared assertion macros, sampled on clk and muted during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every edge
`define HSC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// condition at one edge implies another at the next edge
`define HSC_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

### sv/hsc_pkg.sv
package hsc_pkg;

  // build-time options
  localparam int DUTY_BITS    = 16;
  localparam int POLE_DIVISOR = 4;

  // speed = 60000 / (elapsed * POLE_DIVISOR), folded into one constant dividend
  localparam int SPEED_NUM    = 60000 / POLE_DIVISOR;
  localparam int DIV_BITS     = $clog2(SPEED_NUM + 1);
  localparam int DIV_CNT_W    = $clog2(DIV_BITS + 1);
  localparam int SPEED_SAT    = 4095;
  localparam int EDGE_MIN_MS  = 4;

  localparam logic [15:0] DUTY_MAX = 16'((32'd1 << DUTY_BITS) - 32'd1);

  // configuration register indexes
  localparam logic [1:0] CFG_DUTY   = 2'd0;
  localparam logic [1:0] CFG_OFFSET = 2'd1;
  localparam logic [1:0] CFG_DEAD   = 2'd2;

  // input beat
  typedef struct packed {
    logic        hall_a;
    logic        hall_b;
    logic        hall_c;
    logic [31:0] now_ms;
  } in_item_t;

  // result beat
  typedef struct packed {
    logic        a_high;
    logic [15:0] a_low_duty;
    logic        b_high;
    logic [15:0] b_low_duty;
    logic        c_high;
    logic [15:0] c_low_duty;
    logic [2:0]  step_now;
    logic [15:0] pause_us;
    logic [11:0] speed_rpm;
    logic        last_of_run;
  } out_item_t;

  // divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // base step 1..6 from hall code abc, zero for the two invalid codes
  function automatic logic [2:0] code_step(input logic [2:0] code);
    logic [2:0] s;
    case (code)
      3'b101:  s = 3'd1;
      3'b100:  s = 3'd2;
      3'b110:  s = 3'd3;
      3'b010:  s = 3'd4;
      3'b011:  s = 3'd5;
      3'b001:  s = 3'd6;
      default: s = 3'd0;
    endcase
    return s;
  endfunction

  // remainder by six of a 9-bit value, reciprocal multiply 171/1024
  function automatic logic [2:0] mod6(input logic [8:0] t);
    logic [16:0] prod;
    logic [6:0]  q;
    logic [9:0]  qx6;
    logic [9:0]  r;
    prod = 17'(t) * 17'd171;
    q    = prod[16:10];
    qx6  = 10'(q) * 10'd6;
    r    = 10'(t) - qx6;
    return r[2:0];
  endfunction

endpackage

### sv/hsc_divider.sv
module hsc_divider (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [31:0]       divisor,
  output hsc_pkg::div_stat_t stat,
  output logic [hsc_pkg::DIV_BITS-1:0] quotient
);
  import hsc_pkg::*;

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIV_BITS-1:0]  rem_r, rem_nxt;
  logic [DIV_BITS-1:0]  quo_r, quo_nxt;
  logic [31:0]          dvs_r, dvs_nxt;
  logic [DIV_BITS:0]    shifted;
  logic                 fits;

  // one restoring step: shift next dividend bit in, compare, subtract
  assign shifted = {rem_r, quo_r[DIV_BITS-1]};
  assign fits    = 32'(shifted) >= dvs_r;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DIV_CNT_W'(DIV_BITS);
      rem_nxt  = '0;
      quo_nxt  = DIV_BITS'(SPEED_NUM);
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = fits ? DIV_BITS'(32'(shifted) - dvs_r) : shifted[DIV_BITS-1:0];
      quo_nxt = {quo_r[DIV_BITS-2:0], fits};
      cnt_nxt = cnt_r - DIV_CNT_W'(1);
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;

endmodule

### sv/hsc_drive.sv
module hsc_drive (
  input  logic [2:0]         step,
  input  logic [15:0]        duty,
  input  logic [15:0]        pause,
  input  logic [11:0]        speed,
  input  logic               last,
  output hsc_pkg::out_item_t item
);
  import hsc_pkg::*;

  logic [15:0] duty_eff;

  // clamp duty to the pwm resolution
  assign duty_eff = (duty > DUTY_MAX) ? DUTY_MAX : duty;

  // one high side on, one low side at duty, per commutation step 1..6, all off for any other step
  always_comb begin
    item             = '0;
    item.step_now    = step;
    item.pause_us    = pause;
    item.speed_rpm   = speed;
    item.last_of_run = last;
    case (step)
      3'd1: begin
        item.a_high     = 1'b1;
        item.b_low_duty = duty_eff;
      end
      3'd2: begin
        item.a_high     = 1'b1;
        item.c_low_duty = duty_eff;
      end
      3'd3: begin
        item.b_high     = 1'b1;
        item.c_low_duty = duty_eff;
      end
      3'd4: begin
        item.b_high     = 1'b1;
        item.a_low_duty = duty_eff;
      end
      3'd5: begin
        item.c_high     = 1'b1;
        item.a_low_duty = duty_eff;
      end
      3'd6: begin
        item.c_high     = 1'b1;
        item.b_low_duty = duty_eff;
      end
      default: begin
        item.step_now = step;
      end
    endcase
  end

endmodule

### sv/hall_six_step_commutator.sv
// Six-step BLDC commutator driven by hall samples. Each input beat is one hall
// sample with a millisecond timestamp; it yields one drive beat, preceded by an
// all-off dead-time beat when dead time is enabled and the hall code is valid and changed.
// The first result beat is shown in the cycle after the sample is accepted; when
// a hall A rising edge updates the speed, it first waits for the bit-serial
// divider that forms 60000 / (period * POLE_DIVISOR). No new sample is taken
// until the last result beat of the current one has been accepted, and the next
// one can be taken in the cycle after that. Configuration writes are only allowed
// while the block is idle.
`include "assert_macros.svh"

module hall_six_step_commutator (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  hsc_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output hsc_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_idx,
  input  logic [15:0]        cfg_wdata
);
  import hsc_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]  state_r, state_nxt;
  logic [15:0] duty_r, duty_nxt;
  logic [7:0]  offset_r, offset_nxt;
  logic [15:0] dead_r, dead_nxt;
  logic [2:0]  held_step_r, held_step_nxt;
  logic [2:0]  prev_halls_r, prev_halls_nxt;
  logic        prev_a_r, prev_a_nxt;
  logic [31:0] edge_time_r, edge_time_nxt;
  logic [11:0] speed_r, speed_nxt;
  logic        pause_r, pause_nxt;

  logic        in_acc;
  logic        out_acc;
  logic [2:0]  code;
  logic [2:0]  base;
  logic [8:0]  step_sum;
  logic [31:0] elapsed;
  logic        speed_edge;
  logic        div_start;
  div_stat_t   div_stat;
  logic [DIV_BITS-1:0] div_quo;

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_EMIT);
  assign in_acc    = in_valid && !in_stall;
  assign out_acc   = out_valid && !out_stall;

  // step decode; +132 keeps the sum positive and is a multiple of six
  assign code     = {in_data.hall_a, in_data.hall_b, in_data.hall_c};
  assign base     = code_step(code);
  assign step_sum = 9'(base) - 9'd1 + {offset_r[7], offset_r} + 9'd132;

  // speed update on a hall a rising edge after the minimum period
  assign elapsed    = in_data.now_ms - edge_time_r;
  assign speed_edge = in_data.hall_a && !prev_a_r && (elapsed > 32'(EDGE_MIN_MS));
  assign div_start  = in_acc && speed_edge;

  hsc_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .divisor  (elapsed),
    .stat     (div_stat),
    .quotient (div_quo)
  );

  // sequencer and state update
  always_comb begin
    state_nxt      = state_r;
    duty_nxt       = duty_r;
    offset_nxt     = offset_r;
    dead_nxt       = dead_r;
    held_step_nxt  = held_step_r;
    prev_halls_nxt = prev_halls_r;
    prev_a_nxt     = prev_a_r;
    edge_time_nxt  = edge_time_r;
    speed_nxt      = speed_r;
    pause_nxt      = pause_r;

    if (cfg_we) begin
      case (cfg_idx)
        CFG_DUTY:   duty_nxt   = cfg_wdata;
        CFG_OFFSET: offset_nxt = cfg_wdata[7:0];
        CFG_DEAD:   dead_nxt   = cfg_wdata;
        default:    duty_nxt   = duty_r;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          prev_a_nxt = in_data.hall_a;
          if (base != 3'd0) begin
            held_step_nxt = mod6(step_sum) + 3'd1;
            if ((dead_r != 16'd0) && (code != prev_halls_r)) begin
              pause_nxt      = 1'b1;
              prev_halls_nxt = code;
            end
          end
          if (speed_edge) begin
            edge_time_nxt = in_data.now_ms;
            state_nxt     = ST_DIV;
          end else begin
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          speed_nxt = (32'(div_quo) > 32'(SPEED_SAT)) ? 12'(SPEED_SAT) : 12'(div_quo);
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_acc) begin
          if (pause_r) begin
            pause_nxt = 1'b0;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      duty_r       <= '0;
      offset_r     <= '0;
      dead_r       <= '0;
      held_step_r  <= '0;
      prev_halls_r <= '0;
      prev_a_r     <= 1'b0;
      edge_time_r  <= '0;
      speed_r      <= '0;
      pause_r      <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      duty_r       <= duty_nxt;
      offset_r     <= offset_nxt;
      dead_r       <= dead_nxt;
      held_step_r  <= held_step_nxt;
      prev_halls_r <= prev_halls_nxt;
      prev_a_r     <= prev_a_nxt;
      edge_time_r  <= edge_time_nxt;
      speed_r      <= speed_nxt;
      pause_r      <= pause_nxt;
    end
  end

  // result beat: dead-time pause first, then the drive
  hsc_drive u_drive (
    .step  (pause_r ? 3'd0 : held_step_r),
    .duty  (duty_r),
    .pause (pause_r ? dead_r : 16'd0),
    .speed (speed_r),
    .last  (!pause_r),
    .item  (out_data)
  );

  // checks
  `HSC_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "accept did not start work")
  `HSC_ASSERT(a_no_overlap, !(out_valid && !in_stall), "result shown while taking input")
  `HSC_ASSERT(a_div_idle_on_emit, !(out_valid && div_stat.busy), "result shown before speed ready")
  `HSC_ASSERT(a_pause_all_off, !(out_valid && pause_r && (out_data.step_now != 3'd0 || out_data.last_of_run)), "pause beat not all off")

endmodule
